### hdl/rn48ct_pkg.sv
// Package for the node-48 child table: sizes, operation and status codes,
// and the controller state type.
// No dependencies; imported by radix_node48_child_table and its testbench.
`default_nettype none

package rn48ct_pkg;

  localparam int SLOT_COUNT  = 48;
  localparam int KEY_SPACE   = 256;
  localparam int CHILD_WIDTH = 64;

  localparam int SLOT_W  = 6;
  localparam int KEY_W   = 8;
  localparam int CHILD_W = 64;

  // Index value meaning "no slot", and the first key outside the index.
  localparam logic [SLOT_W-1:0] SLOT_EMPTY = SLOT_W'(SLOT_COUNT);
  localparam logic [KEY_W:0]    KEY_LIMIT  = (KEY_W+1)'(KEY_SPACE);

  localparam logic [CHILD_W-1:0] CHILD_MASK =
      (CHILD_WIDTH >= CHILD_W) ? {CHILD_W{1'b1}}
                               : CHILD_W'((65'd1 << CHILD_WIDTH) - 65'd1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_CHANGE = 3'd3,
    OP_RANGE  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_REFUSED   = 2'd2,
    ST_ABSENT    = 2'd3
  } status_t;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_INS_RD   = 11'b000_0000_0010,
    S_INS_CHK  = 11'b000_0000_0100,
    S_RM_CHK   = 11'b000_0000_1000,
    S_LK_IDX   = 11'b000_0001_0000,
    S_LK_CHILD = 11'b000_0010_0000,
    S_CH_IDX   = 11'b000_0100_0000,
    S_RG_IDX   = 11'b000_1000_0000,
    S_RG_SLOT  = 11'b001_0000_0000,
    S_RG_CHILD = 11'b010_0000_0000,
    S_EMIT     = 11'b100_0000_0000
  } state_t;

endpackage

`default_nettype wire

### hdl/radix_node48_child_table.sv
// Child table of a node-48 radix-tree node: key index memory, child slot
// memory and the controller that reads, modifies and writes them back.
// Depends on rn48ct_pkg.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------------
//  s_      | in        | s_tvalid/s_tready | tuser opcode; tdata key, end_key, child, force
//  m_      | out       | m_tvalid/m_tready | tuser status, found; tdata key, child,
//          |           |                   | live count; tlast end of run
//  cfg_    | in        | cfg_valid/ready   | shrink threshold
//
// Insert steps the cursor past occupied slots, reading each one; a range visits
// the keys from key up to end_key and stops after 48 pairs. Reset clears the
// valid bits of both memories at once; no clearing pass. A result waits in the
// output register while the next item is accepted; the controller stalls only
// to hand on a further result.
`default_nettype none

module radix_node48_child_table
  import rn48ct_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // key [7:0], end_key [15:8], child_value [79:16], force_req [80], zero fill
  input  wire  [87:0] s_tdata,
  // opcode [2:0]
  input  wire  [2:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // key_out [7:0], child_out [71:8], live_count [77:72], zero fill
  output logic [79:0] m_tdata,
  // status [1:0], found [2]
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [5:0]  cfg_data
);

  // Input field views.
  logic [KEY_W-1:0]   in_key;
  logic [KEY_W-1:0]   in_end;
  logic [CHILD_W-1:0] in_child;
  logic               in_force;
  opcode_t            in_op;

  assign in_key   = s_tdata[7:0];
  assign in_end   = s_tdata[15:8];
  assign in_child = s_tdata[79:16] & CHILD_MASK;
  assign in_force = s_tdata[80];
  assign in_op    = opcode_t'(s_tuser);

  // Control registers.
  state_t            state, state_next;
  logic [SLOT_W-1:0] cursor, cursor_next;
  logic [SLOT_W-1:0] live_children, live_next;
  logic [SLOT_W-1:0] shrink_threshold;
  logic [SLOT_W-1:0] rg_count, rg_count_next;

  // Request and pending-result registers.
  logic [KEY_W-1:0]   req_key, req_key_next;
  logic [KEY_W-1:0]   req_end, req_end_next;
  logic [CHILD_W-1:0] req_child, req_child_next;
  logic [KEY_W:0]     rg_key, rg_key_next;
  status_t            em_status, em_status_next;
  logic               em_found, em_found_next;
  logic [KEY_W-1:0]   em_key, em_key_next;
  logic [CHILD_W-1:0] em_child, em_child_next;

  // Output register.
  logic               out_load;
  logic               out_last_val;
  status_t            out_status;
  logic               out_found;
  logic [KEY_W-1:0]   out_key;
  logic [CHILD_W-1:0] out_child;
  logic [SLOT_W-1:0]  out_live;
  logic               out_last;
  logic               out_free;

  // Memories and their valid bits; an entry not valid reads as its reset value.
  logic [SLOT_W-1:0]  idx_mem   [KEY_SPACE];
  logic [CHILD_W-1:0] child_mem [SLOT_COUNT];
  logic [KEY_SPACE-1:0]  idx_vld;
  logic [SLOT_COUNT-1:0] child_vld;

  logic               idx_rd_en, idx_we, idx_clr;
  logic [KEY_W-1:0]   idx_rd_addr, idx_wa;
  logic [SLOT_W-1:0]  idx_wd;
  logic [SLOT_W-1:0]  idx_rd_q;
  logic               idx_rd_vq;

  logic               child_rd_en, child_we, child_clr;
  logic [SLOT_W-1:0]  child_rd_addr, child_wa;
  logic [CHILD_W-1:0] child_wd;
  logic [CHILD_W-1:0] child_rd_q;
  logic               child_rd_vq;

  logic [SLOT_W-1:0]  idx_slot;
  logic               idx_hit;
  logic               child_nz;
  logic               key_ok;
  logic               rg_done;

  assign idx_slot = idx_rd_vq ? idx_rd_q : SLOT_EMPTY;
  assign idx_hit  = idx_slot < SLOT_EMPTY;
  assign child_nz = child_rd_vq && (child_rd_q != '0);
  assign key_ok   = {1'b0, in_key} < KEY_LIMIT;
  assign rg_done  = (rg_key > {1'b0, req_end}) || (rg_count == SLOT_EMPTY);
  assign out_free = !m_tvalid || m_tready;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (idx_we) begin
      idx_mem[idx_wa] <= idx_wd;
    end
    if (idx_rd_en) begin
      idx_rd_q  <= idx_mem[idx_rd_addr];
      idx_rd_vq <= idx_vld[idx_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    if (child_rd_en) begin
      child_rd_q  <= child_mem[child_rd_addr];
      child_rd_vq <= child_vld[child_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_vld   <= '0;
      child_vld <= '0;
    end else begin
      if (idx_we) begin
        idx_vld[idx_wa] <= 1'b1;
      end else if (idx_clr) begin
        idx_vld[idx_wa] <= 1'b0;
      end
      if (child_we) begin
        child_vld[child_wa] <= 1'b1;
      end else if (child_clr) begin
        child_vld[child_wa] <= 1'b0;
      end
    end
  end

  // Every write leads straight to a state that issues no read, so a read never
  // meets a write to the same entry in flight.
  always_comb begin
    state_next     = state;
    cursor_next    = cursor;
    live_next      = live_children;
    rg_count_next  = rg_count;
    req_key_next   = req_key;
    req_end_next   = req_end;
    req_child_next = req_child;
    rg_key_next    = rg_key;
    em_status_next = em_status;
    em_found_next  = em_found;
    em_key_next    = em_key;
    em_child_next  = em_child;
    out_load       = 1'b0;
    out_last_val   = 1'b1;
    idx_rd_en      = 1'b0;
    idx_rd_addr    = req_key;
    idx_we         = 1'b0;
    idx_clr        = 1'b0;
    idx_wa         = req_key;
    idx_wd         = cursor;
    child_rd_en    = 1'b0;
    child_rd_addr  = cursor;
    child_we       = 1'b0;
    child_clr      = 1'b0;
    child_wa       = cursor;
    child_wd       = req_child;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          req_key_next   = in_key;
          req_end_next   = in_end;
          req_child_next = in_child;
          rg_key_next    = {1'b0, in_key};
          rg_count_next  = '0;
          em_status_next = ST_OK;
          em_found_next  = 1'b0;
          em_key_next    = '0;
          em_child_next  = '0;
          idx_rd_addr    = in_key;
          state_next     = S_EMIT;
          case (in_op)
            OP_INSERT: begin
              if (key_ok) begin
                state_next = S_INS_RD;
              end else begin
                em_status_next = ST_ABSENT;
              end
            end
            OP_REMOVE: begin
              if (live_children <= shrink_threshold && !in_force) begin
                em_status_next = ST_REFUSED;
              end else if (!key_ok) begin
                em_status_next = ST_ABSENT;
              end else begin
                idx_rd_en  = 1'b1;
                state_next = S_RM_CHK;
              end
            end
            OP_LOOKUP: begin
              if (key_ok) begin
                idx_rd_en  = 1'b1;
                state_next = S_LK_IDX;
              end
            end
            OP_CHANGE: begin
              if (key_ok) begin
                idx_rd_en  = 1'b1;
                state_next = S_CH_IDX;
              end else begin
                em_status_next = ST_ABSENT;
              end
            end
            OP_RANGE: begin
              state_next = S_RG_IDX;
            end
            default: begin
              // Unused codes give a plain empty result.
              state_next = S_EMIT;
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (cursor >= SLOT_EMPTY) begin
          em_status_next = ST_EXHAUSTED;
          state_next     = S_EMIT;
        end else begin
          child_rd_en   = 1'b1;
          child_rd_addr = cursor;
          state_next    = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        cursor_next = cursor + SLOT_W'(1);
        if (child_nz) begin
          state_next = S_INS_RD;
        end else begin
          child_we   = 1'b1;
          child_wa   = cursor;
          idx_we     = 1'b1;
          idx_wa     = req_key;
          idx_wd     = cursor;
          if (live_children < SLOT_EMPTY) begin
            live_next = live_children + SLOT_W'(1);
          end
          state_next = S_EMIT;
        end
      end

      S_RM_CHK: begin
        state_next = S_EMIT;
        if (idx_hit) begin
          child_clr = 1'b1;
          child_wa  = idx_slot;
          idx_clr   = 1'b1;
          idx_wa    = req_key;
          if (live_children != '0) begin
            live_next = live_children - SLOT_W'(1);
          end
        end else begin
          em_status_next = ST_ABSENT;
        end
      end

      S_LK_IDX: begin
        if (idx_hit) begin
          child_rd_en   = 1'b1;
          child_rd_addr = idx_slot;
          state_next    = S_LK_CHILD;
        end else begin
          state_next = S_EMIT;
        end
      end

      S_LK_CHILD: begin
        if (child_nz) begin
          em_found_next = 1'b1;
          em_key_next   = req_key;
          em_child_next = child_rd_q;
        end
        state_next = S_EMIT;
      end

      S_CH_IDX: begin
        state_next = S_EMIT;
        if (idx_hit) begin
          child_we = 1'b1;
          child_wa = idx_slot;
          child_wd = req_child;
        end else begin
          em_status_next = ST_ABSENT;
        end
      end

      S_RG_IDX: begin
        if (rg_done) begin
          // The pair held back, or the empty result, closes the run.
          state_next = S_EMIT;
        end else if (rg_key >= KEY_LIMIT) begin
          rg_key_next = rg_key + (KEY_W+1)'(1);
        end else begin
          idx_rd_en   = 1'b1;
          idx_rd_addr = rg_key[KEY_W-1:0];
          state_next  = S_RG_SLOT;
        end
      end

      S_RG_SLOT: begin
        if (idx_hit) begin
          child_rd_en   = 1'b1;
          child_rd_addr = idx_slot;
          state_next    = S_RG_CHILD;
        end else begin
          rg_key_next = rg_key + (KEY_W+1)'(1);
          state_next  = S_RG_IDX;
        end
      end

      S_RG_CHILD: begin
        if (!child_nz) begin
          rg_key_next = rg_key + (KEY_W+1)'(1);
          state_next  = S_RG_IDX;
        end else if (rg_count == '0 || out_free) begin
          // Each pair is held back one step so that the final one can carry
          // the end-of-run mark.
          if (rg_count != '0) begin
            out_load     = 1'b1;
            out_last_val = 1'b0;
          end
          em_found_next = 1'b1;
          em_key_next   = rg_key[KEY_W-1:0];
          em_child_next = child_rd_q;
          rg_count_next = rg_count + SLOT_W'(1);
          rg_key_next   = rg_key + (KEY_W+1)'(1);
          state_next    = S_RG_IDX;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      cursor           <= '0;
      live_children    <= '0;
      rg_count         <= '0;
      shrink_threshold <= SLOT_W'(12);
      m_tvalid         <= 1'b0;
    end else begin
      state         <= state_next;
      cursor        <= cursor_next;
      live_children <= live_next;
      rg_count      <= rg_count_next;
      if (cfg_valid && cfg_ready) begin
        shrink_threshold <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_key   <= req_key_next;
    req_end   <= req_end_next;
    req_child <= req_child_next;
    rg_key    <= rg_key_next;
    em_status <= em_status_next;
    em_found  <= em_found_next;
    em_key    <= em_key_next;
    em_child  <= em_child_next;
    if (out_load) begin
      out_status <= em_status;
      out_found  <= em_found;
      out_key    <= em_key;
      out_child  <= em_child;
      out_live   <= live_children;
      out_last   <= out_last_val;
    end
  end

  assign m_tdata = {2'b00, out_live, out_child, out_key};
  assign m_tuser = {out_found, out_status};
  assign m_tlast = out_last;

  // A result is never loaded over one that has not been taken.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    (live_children <= SLOT_EMPTY) && (cursor <= SLOT_EMPTY))
    else $error("live count or cursor beyond slot count");

  a_write_then_no_read: assert property (@(posedge clk) disable iff (rst)
    (child_we || child_clr || idx_we || idx_clr) |=> (!idx_rd_en && !child_rd_en))
    else $error("memory read issued right after a write");

  a_child_write_addr: assert property (@(posedge clk) disable iff (rst)
    (child_we || child_clr) |-> (child_wa < SLOT_EMPTY))
    else $error("child slot write out of range");

  a_range_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RG_CHILD && child_nz && (rg_count == '0 || out_free))
      |=> (rg_count == $past(rg_count) + SLOT_W'(1)) && (rg_count <= SLOT_EMPTY))
    else $error("range pair count slipped");

endmodule

`default_nettype wire

### tb/sv/radix_node48_child_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for radix_node48_child_table: a directed opening, then
// random insert/remove/lookup/change/range traffic under several idling phases.
// Depends on rn48ct_pkg and the radix_node48_child_table RTL only.

module radix_node48_child_table_tb;
  import rn48ct_pkg::*;

  localparam int          CYCLE_LIMIT        = 2_000_000;
  localparam int          SETTLE_CYCLES      = 64;
  localparam int          ITEMS_PER_PHASE    = 50;
  localparam logic [5:0]  THRESHOLD_AT_RESET = 6'd12;
  localparam logic [5:0]  THRESHOLD_MAX      = 6'h3F;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [7:0]  key_out;
    logic [63:0] child_out;
    logic [5:0]  live_count;
    logic        last;
  } reply_t;

  // Tracks the node's key index and child slots and queues the replies due.
  class node48_tracker;
    logic [SLOT_W-1:0]  index_of_key [KEY_SPACE];
    logic [CHILD_W-1:0] slot_child [SLOT_COUNT];
    int                 cursor;
    int                 live;
    logic [5:0]         threshold;
    reply_t             replies_due [$];
    int                 mismatches;

    function new();
      foreach (index_of_key[k]) index_of_key[k] = SLOT_EMPTY;
      foreach (slot_child[s]) slot_child[s] = '0;
      cursor     = 0;
      live       = 0;
      threshold  = THRESHOLD_AT_RESET;
      mismatches = 0;
    endfunction

    function int mapped_slot(logic [7:0] key);
      if (index_of_key[key] >= SLOT_COUNT) return -1;
      return int'(index_of_key[key]);
    endfunction

    function void post(status_t st, logic found, logic [7:0] key, logic [63:0] child,
                       logic last);
      reply_t r;
      r.status     = st;
      r.found      = found;
      r.key_out    = key;
      r.child_out  = child & CHILD_MASK;
      r.live_count = 6'(live);
      r.last       = last;
      replies_due.push_back(r);
    endfunction

    function void accept_item(logic [2:0] op, logic [7:0] key, logic [7:0] end_key,
                              logic [63:0] child, logic force_req);
      int     s;
      int     n;
      reply_t tail;
      s = mapped_slot(key);
      n = 0;
      case (op)
        OP_INSERT: begin
          while (cursor < SLOT_COUNT && slot_child[cursor] != '0) cursor++;
          if (cursor >= SLOT_COUNT) begin
            post(ST_EXHAUSTED, 1'b0, '0, '0, 1'b1);
          end else begin
            // A key already mapped simply moves; its old slot stays occupied.
            slot_child[cursor] = child & CHILD_MASK;
            index_of_key[key]  = SLOT_W'(cursor);
            cursor++;
            if (live < SLOT_COUNT) live++;
            post(ST_OK, 1'b0, '0, '0, 1'b1);
          end
        end
        OP_REMOVE: begin
          if (live <= int'(threshold) && !force_req) begin
            post(ST_REFUSED, 1'b0, '0, '0, 1'b1);
          end else if (s < 0) begin
            post(ST_ABSENT, 1'b0, '0, '0, 1'b1);
          end else begin
            slot_child[s]     = '0;
            index_of_key[key] = SLOT_EMPTY;
            if (live > 0) live--;
            post(ST_OK, 1'b0, '0, '0, 1'b1);
          end
        end
        OP_LOOKUP: begin
          if (s >= 0 && slot_child[s] != '0) post(ST_OK, 1'b1, key, slot_child[s], 1'b1);
          else post(ST_OK, 1'b0, '0, '0, 1'b1);
        end
        OP_CHANGE: begin
          if (s < 0) begin
            post(ST_ABSENT, 1'b0, '0, '0, 1'b1);
          end else begin
            slot_child[s] = child & CHILD_MASK;
            post(ST_OK, 1'b0, '0, '0, 1'b1);
          end
        end
        OP_RANGE: begin
          for (int k = int'(key); k <= int'(end_key) && n < SLOT_COUNT; k++) begin
            s = mapped_slot(8'(k));
            if (s >= 0 && slot_child[s] != '0) begin
              post(ST_OK, 1'b1, 8'(k), slot_child[s], 1'b0);
              n++;
            end
          end
          if (n == 0) begin
            post(ST_OK, 1'b0, '0, '0, 1'b1);
          end else begin
            tail = replies_due.pop_back();
            tail.last = 1'b1;
            replies_due.push_back(tail);
          end
        end
        default: post(ST_OK, 1'b0, '0, '0, 1'b1);
      endcase
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("unexpected result: key_out %0d child_out %h", got.key_out, got.child_out);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatches++;
      end
      if (got.key_out !== want.key_out) begin
        $error("key_out: expected %0d, got %0d", want.key_out, got.key_out);
        mismatches++;
      end
      if (got.child_out !== want.child_out) begin
        $error("child_out: expected %h, got %h", want.child_out, got.child_out);
        mismatches++;
      end
      if (got.live_count !== want.live_count) begin
        $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata   = '0;
  logic [2:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [79:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data  = '0;

  node48_tracker tracker;
  reply_t        seen;
  int            send_idle   = 0;
  int            recv_stall  = 0;
  int            cycle_count = 0;
  logic [7:0]    key_pool [16];

  radix_node48_child_table dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("radix_node48_child_table_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_stall);

  assign seen = {m_tuser[1:0], m_tuser[2], m_tdata[7:0], m_tdata[71:8], m_tdata[77:72],
                 m_tlast};

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_reply(seen);
  end

  task automatic send_item(logic [2:0] op, logic [7:0] key, logic [7:0] end_key,
                           logic [63:0] child, logic force_req);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, force_req, child, end_key, key};
    do @(posedge clk); while (!s_tready);
    tracker.accept_item(op, key, end_key, child, force_req);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.threshold = value;
  endtask

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, 15)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_item(int ins_pct);
    logic [2:0]  op;
    logic [7:0]  key;
    logic [7:0]  end_key;
    logic [63:0] child;
    int          r;
    key     = pick_key();
    end_key = 8'($urandom_range(0, 255));
    r       = $urandom_range(0, 99);
    child   = (r < 8) ? '0 : (r < 13) ? '1 : {$urandom, $urandom};
    r       = $urandom_range(0, 99);
    if (r < ins_pct) begin
      op = OP_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 27)      op = OP_REMOVE;
      else if (r < 55) op = OP_LOOKUP;
      else if (r < 77) op = OP_CHANGE;
      else if (r < 95) op = OP_RANGE;
      else             op = 3'(OP_RANGE) + 3'($urandom_range(1, 3));
    end
    if (op == OP_RANGE) begin
      r = $urandom_range(0, 99);
      // Mostly short spans; some reversed spans, and a few sweeps over nearly the whole index.
      if (r < 85) begin
        end_key = (int'(key) + 24 > 255) ? 8'd255 : key + 8'($urandom_range(0, 24));
      end else if (r < 93) begin
        key = 8'($urandom_range(1, 255));
        end_key = 8'($urandom_range(0, int'(key) - 1));
      end else begin
        key = 8'($urandom_range(0, 3));
        end_key = 8'($urandom_range(252, 255));
      end
    end
    send_item(op, key, end_key, child, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    tracker = new();
    key_pool[0]  = 8'h00;
    key_pool[15] = 8'hFF;
    for (int i = 1; i < 15; i++) key_pool[i] = 8'($urandom_range(0, 255));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty node, refusal ahead of the absence check, then a small population
    // with a zero child and a remapped key.
    send_item(OP_LOOKUP, 8'h00, 8'hFF, '0, 1'b0);
    send_item(OP_RANGE, 8'h00, 8'hFF, '0, 1'b1);
    send_item(OP_REMOVE, 8'h05, 8'h00, '0, 1'b0);
    send_item(OP_REMOVE, 8'h05, 8'h00, '0, 1'b1);
    send_item(OP_CHANGE, 8'h07, 8'hFF, 64'h1, 1'b0);
    send_item(OP_INSERT, 8'h00, 8'h00, '1, 1'b0);
    send_item(OP_INSERT, 8'hFF, 8'hFF, 64'h8000_0000_0000_0001, 1'b1);
    send_item(OP_INSERT, 8'h55, 8'h00, '0, 1'b0);
    send_item(OP_INSERT, 8'hAA, 8'h00, 64'h5555_5555_5555_5555, 1'b0);
    send_item(OP_INSERT, 8'h00, 8'h00, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_item(OP_LOOKUP, 8'h00, 8'h00, '0, 1'b0);
    send_item(OP_LOOKUP, 8'h55, 8'h00, '0, 1'b0);
    send_item(OP_RANGE, 8'h00, 8'hFF, '0, 1'b0);
    send_item(OP_RANGE, 8'd200, 8'd100, '0, 1'b0);
    send_item(OP_CHANGE, 8'h55, 8'h00, 64'h1234, 1'b0);
    send_item(OP_CHANGE, 8'hAA, 8'h00, '0, 1'b1);
    send_item(OP_LOOKUP, 8'hAA, 8'h00, '0, 1'b0);
    send_item(OP_REMOVE, 8'hFF, 8'h00, '0, 1'b0);
    send_item(OP_REMOVE, 8'hFF, 8'h00, '0, 1'b1);
    send_item(OP_LOOKUP, 8'hFF, 8'h00, '0, 1'b0);
    send_item(3'(OP_RANGE) + 3'd1, 8'h12, 8'h34, '1, 1'b1);
    send_item(3'(OP_RANGE) + 3'd2, 8'h00, 8'h00, '0, 1'b0);
    send_item(3'(OP_RANGE) + 3'd3, 8'hFF, 8'hFF, '1, 1'b1);
    send_item(OP_RANGE, 8'h50, 8'h60, '0, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      wait_quiet();
      case (phase)
        0: begin
          write_threshold('0);
          send_idle = 0;  recv_stall = 0;
        end
        1: begin
          write_threshold(6'(SLOT_COUNT));
          send_idle = 47; recv_stall = 0;
        end
        2: begin
          write_threshold(6'($urandom_range(1, SLOT_COUNT - 1)));
          send_idle = 0;  recv_stall = 47;
        end
        default: begin
          write_threshold(THRESHOLD_MAX);
          send_idle = 24; recv_stall = 24;
        end
      endcase
      // Slots are never reclaimed, so inserts are rationed to run out late.
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_item((phase == 3) ? 40 : 25);
        if ($urandom_range(0, 39) == 0) wait_quiet();
      end
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) $display("radix_node48_child_table_tb: clean");
    else $display("radix_node48_child_table_tb: errors");
    $finish;
  end

endmodule
